>>> sv/ae_pkg.sv
// Shared constants and types for the arithmetic encoder.
// No dependencies; every other file of the block imports this package.
package ae_pkg;

	// interval and probability precision
	localparam int PRECISION   = 32;
	localparam int PROB_BITS   = 16;
	// bytes kept per item, further bytes are dropped
	localparam int MAX_RESULTS = 10;

	// multiplier digit width and digit count over a cumulative bound
	localparam int CW     = PROB_BITS + 1;
	localparam int DIGIT  = 4;
	localparam int NDIG   = (CW + DIGIT - 1) / DIGIT;

	localparam int ITER_W = $clog2(PRECISION + 1);
	localparam int RES_W  = $clog2(MAX_RESULTS + 1);

	// one as a PRECISION-bit fraction
	localparam logic [PRECISION:0] ONE_P = {1'b1, {PRECISION{1'b0}}};

	// saturation limits on the 17-bit and 16-bit input bounds
	localparam logic [16:0] CH_MAX = 17'(2 ** PROB_BITS);
	localparam logic [15:0] CL_MAX = 16'(2 ** PROB_BITS - 1);

	// commands to the byte packer
	typedef enum logic [1:0] {
		PK_NONE,
		PK_BIT,
		PK_PAD,
		PK_CLOSE
	} pk_op_t;

	typedef struct packed {
		pk_op_t op;
		logic   bit_val;
		logic   fin;
	} pk_cmd_t;

endpackage

>>> sv/ae_scaler.sv
// Digit-serial scaler: floor(span * c / 2^PROB_BITS) for both symbol bounds.
// Depends on ae_pkg.
module ae_scaler (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ae_pkg::PRECISION:0] span,
	input  logic [ae_pkg::CW-1:0]     c_low,
	input  logic [ae_pkg::CW-1:0]     c_high,
	output logic                      done,
	output logic [ae_pkg::PRECISION:0] s_low,
	output logic [ae_pkg::PRECISION:0] s_high
);
	import ae_pkg::*;

	localparam int DW    = NDIG * DIGIT;
	localparam int ACC_W = PRECISION + 1 + DW;
	localparam int PW    = PRECISION + 1 + DIGIT;
	localparam int CNT_W = $clog2(NDIG + 1);

	logic [PRECISION:0] span_q;
	logic [DW-1:0]      dl_q, dh_q;
	logic [ACC_W-1:0]   acc_l_q, acc_h_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q, done_q;

	logic [PW-1:0]      prod_l, prod_h;
	logic [ACC_W-1:0]   acc_l_n, acc_h_n;

	// one digit of each bound per cycle, most significant first
	always_comb begin
		prod_l  = PW'(span_q) * PW'(dl_q[DW-1 -: DIGIT]);
		prod_h  = PW'(span_q) * PW'(dh_q[DW-1 -: DIGIT]);
		acc_l_n = (acc_l_q << DIGIT) + ACC_W'(prod_l);
		acc_h_n = (acc_h_q << DIGIT) + ACC_W'(prod_h);
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(NDIG);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			span_q  <= span;
			dl_q    <= DW'(c_low);
			dh_q    <= DW'(c_high);
			acc_l_q <= '0;
			acc_h_q <= '0;
		end else if (busy_q) begin
			dl_q    <= dl_q << DIGIT;
			dh_q    <= dh_q << DIGIT;
			acc_l_q <= acc_l_n;
			acc_h_q <= acc_h_n;
		end
	end

	assign done   = done_q;
	assign s_low  = acc_l_q[PROB_BITS +: PRECISION + 1];
	assign s_high = acc_h_q[PROB_BITS +: PRECISION + 1];

endmodule

>>> sv/ae_pack.sv
// Byte packer: gathers code bits, holds one byte back to mark the last of an
// item, and drives the output register. Depends on ae_pkg.
module ae_pack (
	input  logic            clk,
	input  logic            arst_n,
	input  ae_pkg::pk_cmd_t cmd,
	output logic            cmd_ready,
	output logic            byte_valid,
	input  logic            byte_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run,
	output logic            stream_end
);
	import ae_pkg::*;

	logic [6:0]       gather_q;
	logic [2:0]       count_q;
	logic [7:0]       hold_q;
	logic             hold_vld_q;
	logic [RES_W-1:0] res_q;
	logic [7:0]       out_byte_q;
	logic             last_q, end_q, out_vld_q;

	logic       out_busy, form, keep, move_hold, fire;
	logic [7:0] new_byte;

	// byte formation and stall decision
	always_comb begin
		out_busy = out_vld_q && !byte_ready;
		form     = ((cmd.op == PK_BIT) && (count_q == 3'd7)) ||
		           ((cmd.op == PK_PAD) && (count_q != 3'd0));
		if (cmd.op == PK_BIT)
			new_byte = {gather_q, cmd.bit_val};
		else
			new_byte = 8'({1'b0, gather_q} << (4'd8 - {1'b0, count_q}));
		keep      = res_q < RES_W'(MAX_RESULTS);
		move_hold = hold_vld_q && ((form && keep) || (cmd.op == PK_CLOSE));
		cmd_ready = !(move_hold && out_busy);
		fire      = (cmd.op != PK_NONE) && cmd_ready;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q   <= '0;
			count_q    <= '0;
			hold_vld_q <= 1'b0;
			res_q      <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (fire && move_hold)
				out_vld_q <= 1'b1;
			else if (out_vld_q && byte_ready)
				out_vld_q <= 1'b0;
			if (fire) begin
				case (cmd.op)
					PK_BIT: begin
						if (count_q == 3'd7) begin
							gather_q <= '0;
							count_q  <= '0;
						end else begin
							gather_q <= {gather_q[5:0], cmd.bit_val};
							count_q  <= count_q + 3'd1;
						end
					end
					PK_PAD: begin
						gather_q <= '0;
						count_q  <= '0;
					end
					PK_CLOSE: begin
						hold_vld_q <= 1'b0;
						res_q      <= '0;
					end
					default: ;
				endcase
				if (form && keep) begin
					hold_vld_q <= 1'b1;
					res_q      <= res_q + RES_W'(1);
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (fire && form && keep)
			hold_q <= new_byte;
		if (fire && move_hold) begin
			out_byte_q <= hold_q;
			last_q     <= cmd.op == PK_CLOSE;
			end_q      <= (cmd.op == PK_CLOSE) && cmd.fin;
		end
	end

	assign byte_valid  = out_vld_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign stream_end  = end_q;

endmodule

>>> sv/arithmetic_encoder.sv
// Arithmetic encoder over a fixed-point interval [low, high).
// Usage:
//  Input channel sym_valid/sym_ready carries one item: cum_low, cum_high,
//  has_symbol, finish. Output channel byte_valid/byte_ready carries code bytes,
//  first bit in the MSB; last_of_run marks the last byte of an item and
//  stream_end the final byte of a finished stream.
//  One item is handled at a time; sym_ready is high only when the sequencer
//  is idle. Closing an item waits until its held byte can enter the output.
//  Steps per item: a symbol item shifts out its renormalisation bits, one
//   per cycle while the packer takes them, then runs the digit-serial scaler
//   (4-bit digits over the bound). finish then shifts out the midpoint bits
//   (at most 33) and pads; an item with neither flag goes straight to close.
//  A byte appears on the output one item-byte later than it is formed, since
//  the packer holds one byte back to mark it; the last one leaves at close.
//  When the receiver stalls, bit emission stops once a new byte is formed while
//  the held byte and the output register are full, and resumes as soon as the output is taken.
//  Reset (arst_n low) returns the interval to [0, 1), empties the packer and
//  drops any byte not yet taken.
// Depends on ae_pkg, ae_scaler and ae_pack.
module arithmetic_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sym_valid,
	output logic        sym_ready,
	input  logic [15:0] cum_low,
	input  logic [16:0] cum_high,
	input  logic        has_symbol,
	input  logic        finish,
	output logic        byte_valid,
	input  logic        byte_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        stream_end
);
	import ae_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RENORM,
		S_MUL,
		S_FIN_LOAD,
		S_FIN_SHIFT,
		S_CLOSE
	} state_t;

	state_t              state_q;
	logic [PRECISION-1:0] low_q;
	logic [PRECISION:0]  high_q;
	logic [PRECISION:0]  m_q;
	logic [ITER_W-1:0]   iter_q;
	logic [CW-1:0]       cl_q, ch_q;
	logic                fin_q;

	logic [16:0]         ch_sat, cl_clamp;
	logic [15:0]         cl_sat;
	logic                renorm_go;
	logic [PRECISION:0]  span;
	logic                sc_start, sc_done;
	logic [PRECISION:0]  sc_low, sc_high;
	pk_cmd_t             pk_cmd;
	logic                pk_ready;
	logic                accept;

	// bound saturation on the incoming item
	always_comb begin
		ch_sat   = (cum_high > CH_MAX) ? CH_MAX : cum_high;
		cl_sat   = (cum_low > CL_MAX) ? CL_MAX : cum_low;
		cl_clamp = ({1'b0, cl_sat} > ch_sat) ? ch_sat : {1'b0, cl_sat};
	end

	assign sym_ready = state_q == S_IDLE;
	assign accept    = sym_valid && sym_ready;

	// renormalisation test and span for the scaler
	always_comb begin
		renorm_go = !high_q[PRECISION] && (low_q[PRECISION-1] == high_q[PRECISION-1]) &&
		            (iter_q < ITER_W'(PRECISION));
		span      = high_q - {1'b0, low_q};
		sc_start  = (state_q == S_RENORM) && !renorm_go;
	end

	// packer command
	always_comb begin
		pk_cmd.op      = PK_NONE;
		pk_cmd.bit_val = 1'b0;
		pk_cmd.fin     = fin_q;
		case (state_q)
			S_RENORM: begin
				if (renorm_go) begin
					pk_cmd.op      = PK_BIT;
					pk_cmd.bit_val = low_q[PRECISION-1];
				end
			end
			S_FIN_SHIFT: begin
				if (m_q != '0) begin
					pk_cmd.op      = PK_BIT;
					pk_cmd.bit_val = m_q[PRECISION];
				end else begin
					pk_cmd.op = PK_PAD;
				end
			end
			S_CLOSE: pk_cmd.op = PK_CLOSE;
			default: ;
		endcase
	end

	// sequencer and interval registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			low_q   <= '0;
			high_q  <= ONE_P;
			iter_q  <= '0;
			fin_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						fin_q  <= finish;
						iter_q <= '0;
						if (has_symbol)
							state_q <= S_RENORM;
						else if (finish)
							state_q <= S_FIN_LOAD;
						else
							state_q <= S_CLOSE;
					end
				end
				S_RENORM: begin
					if (renorm_go) begin
						if (pk_ready) begin
							low_q  <= {low_q[PRECISION-2:0], 1'b0};
							high_q <= {1'b0, high_q[PRECISION-2:0], 1'b0};
							iter_q <= iter_q + ITER_W'(1);
						end
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (sc_done) begin
						high_q  <= {1'b0, low_q} + sc_high;
						low_q   <= PRECISION'({1'b0, low_q} + sc_low);
						state_q <= fin_q ? S_FIN_LOAD : S_CLOSE;
					end
				end
				S_FIN_LOAD: state_q <= S_FIN_SHIFT;
				S_FIN_SHIFT: begin
					if (pk_ready && (m_q == '0))
						state_q <= S_CLOSE;
				end
				S_CLOSE: begin
					if (pk_ready) begin
						if (fin_q) begin
							low_q  <= '0;
							high_q <= ONE_P;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and midpoint shift register
	always_ff @(posedge clk) begin
		if (accept) begin
			cl_q <= cl_clamp[CW-1:0];
			ch_q <= ch_sat[CW-1:0];
		end
		if (state_q == S_FIN_LOAD)
			m_q <= {1'b0, low_q} + high_q;
		else if ((state_q == S_FIN_SHIFT) && (m_q != '0) && pk_ready)
			m_q <= m_q << 1;
	end

	ae_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.span   (span),
		.c_low  (cl_q),
		.c_high (ch_q),
		.done   (sc_done),
		.s_low  (sc_low),
		.s_high (sc_high)
	);

	ae_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (pk_cmd),
		.cmd_ready   (pk_ready),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.stream_end  (stream_end)
	);

	// checks
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && stream_end |-> last_of_run)
		else $error("stream_end without last_of_run");

	a_interval_order: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, low_q} <= high_q) && (high_q <= ONE_P))
		else $error("interval bounds out of order");

	a_finish_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOSE) && pk_ready && fin_q |=> (low_q == '0) && (high_q == ONE_P))
		else $error("interval not reset after finish");

	a_renorm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= ITER_W'(PRECISION))
		else $error("renormalisation ran past the precision");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for arithmetic_encoder: a bit-exact model of the coding interval
// predicts every code byte, and each byte taken from the output is checked against it.
// Depends on ae_pkg and the arithmetic_encoder RTL.

module testbench;
	import ae_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 100;
	localparam int RANDOM_ITEMS   = 410;

	typedef struct packed {
		logic [7:0] code;
		logic       last_of_run;
		logic       stream_end;
	} code_byte_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        sym_valid  = 1'b0;
	logic [15:0] cum_low    = '0;
	logic [16:0] cum_high   = '0;
	logic        has_symbol = 1'b0;
	logic        finish     = 1'b0;
	logic        byte_ready = 1'b0;
	logic        sym_ready;
	logic        byte_valid;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        stream_end;

	// model of the coding interval and the byte packer
	logic [PRECISION-1:0] code_low;
	logic [PRECISION:0]   code_high;
	logic [6:0]           gather_bits;
	logic [2:0]           gather_cnt;

	code_byte_t expected_bytes[$];
	code_byte_t item_bytes[$];
	int         errors      = 0;
	int         idle_cycles = 0;
	bit         send_idle   = 1'b1;
	bit         recv_idle   = 1'b1;

	arithmetic_encoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.sym_valid   (sym_valid),
		.sym_ready   (sym_ready),
		.cum_low     (cum_low),
		.cum_high    (cum_high),
		.has_symbol  (has_symbol),
		.finish      (finish),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.stream_end  (stream_end)
	);

	always #2 clk = ~clk;

	// interval back to [0, 1), packer empty
	task automatic clear_coder();
		code_low    = '0;
		code_high   = ONE_P;
		gather_bits = '0;
		gather_cnt  = '0;
	endtask

	// bytes past the per-item cap are dropped
	task automatic emit_code(input logic [7:0] b);
		code_byte_t cb;
		cb.code        = b;
		cb.last_of_run = 1'b0;
		cb.stream_end  = 1'b0;
		if (item_bytes.size() < MAX_RESULTS)
			item_bytes.insert(item_bytes.size(), cb);
	endtask

	task automatic shift_bit(input logic b);
		if (gather_cnt == 3'd7) begin
			emit_code({gather_bits, b});
			gather_bits = '0;
			gather_cnt  = '0;
		end else begin
			gather_bits = {gather_bits[5:0], b};
			gather_cnt  = gather_cnt + 3'd1;
		end
	endtask

	// floor(span * c / 2^PROB_BITS)
	function automatic logic [PRECISION:0] scale_span(input logic [PRECISION:0] span,
			input logic [16:0] c);
		logic [63:0] prod;
		logic [63:0] shifted;
		prod    = 64'(span) * 64'(c);
		shifted = prod >> PROB_BITS;
		return shifted[PRECISION:0];
	endfunction

	// predict the bytes caused by one accepted item and queue them
	task automatic encode_item(input logic [15:0] cl, input logic [16:0] ch,
			input logic has, input logic fin);
		logic [16:0]        ch_sat;
		logic [15:0]        cl_sat;
		logic [PRECISION:0] span;
		logic [PRECISION:0] low_sum;
		logic [63:0]        mid;
		logic [63:0]        one64;
		logic               b;
		one64 = 64'd1 << PRECISION;
		item_bytes.delete();
		if (has) begin
			// renormalise while the top bits of both bounds agree
			for (int i = 0; i < PRECISION; i++) begin
				if ({1'b0, code_low[PRECISION-1]} != code_high[PRECISION:PRECISION-1])
					break;
				shift_bit(code_low[PRECISION-1]);
				code_low  = {code_low[PRECISION-2:0], 1'b0};
				code_high = {1'b0, code_high[PRECISION-2:0], 1'b0};
			end
			// saturate and order the bounds
			ch_sat = (ch > CH_MAX) ? CH_MAX : ch;
			cl_sat = (cl > CL_MAX) ? CL_MAX : cl;
			if ({1'b0, cl_sat} > ch_sat)
				cl_sat = ch_sat[15:0];
			// narrow to the symbol's share, both from the old low bound
			span      = code_high - {1'b0, code_low};
			code_high = {1'b0, code_low} + scale_span(span, ch_sat);
			low_sum   = {1'b0, code_low} + scale_span(span, {1'b0, cl_sat});
			code_low  = low_sum[PRECISION-1:0];
		end
		if (fin) begin
			// midpoint bits down to the lowest set one, then pad
			mid = 64'(code_high) + 64'(code_low);
			for (int i = 0; i <= PRECISION && mid != 64'd0; i++) begin
				b = (mid >= one64);
				shift_bit(b);
				mid = (mid - (b ? one64 : 64'd0)) << 1;
			end
			if (gather_cnt != 3'd0)
				emit_code({1'b0, gather_bits} << (8 - gather_cnt));
			if (item_bytes.size() > 0)
				item_bytes[item_bytes.size()-1].stream_end = 1'b1;
			clear_coder();
		end
		if (item_bytes.size() > 0)
			item_bytes[item_bytes.size()-1].last_of_run = 1'b1;
		foreach (item_bytes[i])
			expected_bytes.insert(expected_bytes.size(), item_bytes[i]);
	endtask

	task automatic flag_error(input string msg);
		if (errors < 10)
			$display("ERROR: %s", msg);
		errors++;
	endtask

	// send one item; returns at the edge where it is accepted
	task automatic send_item(input logic [15:0] cl, input logic [16:0] ch,
			input logic has, input logic fin);
		int gap;
		gap = send_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			sym_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sym_valid  <= 1'b1;
		cum_low    <= cl;
		cum_high   <= ch;
		has_symbol <= has;
		finish     <= fin;
		do @(posedge clk); while (!sym_ready);
		encode_item(cl, ch, has, fin);
	endtask

	// hold the input off until every predicted byte has arrived
	task automatic wait_for_results();
		sym_valid <= 1'b0;
		do @(posedge clk); while (expected_bytes.size() != 0);
	endtask

	// finish straight after reset, empty and skipped items
	task automatic test_reset_flush();
		send_item(16'd0, 17'd0, 1'b0, 1'b1);
		send_item(16'd0, 17'd0, 1'b0, 1'b0);
		send_item(16'd12345, 17'd54321, 1'b0, 1'b0);
		send_item(16'd0, 17'd65536, 1'b1, 1'b0);
		send_item(16'd0, 17'd65536, 1'b1, 1'b1);
	endtask

	// saturation of both bounds, clamped and zero shares
	task automatic test_bound_limits();
		send_item(16'd65535, 17'h1FFFF, 1'b1, 1'b0);
		send_item(16'd65535, 17'd65536, 1'b1, 1'b0);
		send_item(16'd0, 17'd65536, 1'b1, 1'b1);
		send_item(16'd20000, 17'd50000, 1'b1, 1'b0);
		send_item(16'd40000, 17'd30000, 1'b1, 1'b0);
		send_item(16'd100, 17'd200, 1'b1, 1'b0);
		send_item(16'd7, 17'd9, 1'b1, 1'b1);
		send_item(16'hFFFF, 17'd0, 1'b1, 1'b1);
	endtask

	// collapsed interval at zero: finishing yields no byte at all
	task automatic test_empty_midpoint();
		send_item(16'd0, 17'd0, 1'b1, 1'b0);
		send_item(16'd0, 17'd0, 1'b0, 1'b1);
		send_item(16'd1, 17'd3, 1'b1, 1'b1);
	endtask

	// very narrow shares force long renormalisation runs
	task automatic test_narrow_shares();
		send_item(16'd0, 17'd1, 1'b1, 1'b0);
		send_item(16'd65535, 17'd65536, 1'b1, 1'b0);
		send_item(16'd32767, 17'd32768, 1'b1, 1'b0);
		send_item(16'd43690, 17'd43691, 1'b1, 1'b0);
		send_item(16'd1, 17'd2, 1'b1, 1'b1);
	endtask

	// streams of symbols closed by a finish, with some noise and broken items
	task automatic test_random_streams(input int n_items);
		int          sent;
		int          kind;
		int          len;
		bit          paused;
		logic [15:0] cl;
		logic [16:0] ch;
		logic        has;
		logic        fin;
		sent   = 0;
		paused = 1'b0;
		while (sent < n_items) begin
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			len = $urandom_range(1, 8);
			for (int s = 0; s < len; s++) begin
				kind = $urandom_range(0, 99);
				has  = 1'b1;
				fin  = (s == len - 1);
				cl   = 16'($urandom);
				if (kind < 60) begin
					ch = 17'($urandom_range(65536, int'(cl) + 1));
				end else if (kind < 80) begin
					ch = 17'(int'(cl) + $urandom_range(1, 16));
				end else if (kind < 88) begin
					// no symbol: ignored unless it closes the stream
					ch  = 17'($urandom);
					has = 1'b0;
				end else if (kind < 96) begin
					case ($urandom_range(0, 2))
						0: ch = 17'($urandom_range(int'(cl), 0));
						1: ch = 17'($urandom_range(131071, 65537));
						default: ch = 17'd0;
					endcase
				end else begin
					ch  = 17'($urandom);
					has = 1'($urandom);
					fin = 1'($urandom);
				end
				send_item(cl, ch, has, fin);
				if (has || fin)
					sent++;
			end
			if (!paused && sent >= n_items / 2) begin
				wait_for_results();
				paused = 1'b1;
			end
		end
	endtask

	// receiver: random stalls, each taken byte checked against the oldest prediction
	initial begin
		int         stall;
		code_byte_t want;
		code_byte_t got;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = recv_idle ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				byte_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			byte_ready <= 1'b1;
			do @(posedge clk); while (!byte_valid);
			got = '{code: out_byte, last_of_run: last_of_run, stream_end: stream_end};
			if (expected_bytes.size() == 0) begin
				flag_error($sformatf("unexpected byte %02h last %0b end %0b",
					got.code, got.last_of_run, got.stream_end));
			end else begin
				want = expected_bytes.pop_front();
				if (got !== want)
					flag_error($sformatf(
						"expected byte %02h last %0b end %0b, got %02h last %0b end %0b",
						want.code, want.last_of_run, want.stream_end,
						got.code, got.last_of_run, got.stream_end));
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sym_valid && sym_ready) || (byte_valid && byte_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	initial begin
		clear_coder();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_flush();
		test_bound_limits();
		wait_for_results();
		test_empty_midpoint();
		test_narrow_shares();
		test_random_streams(RANDOM_ITEMS);
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_bytes.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
sv/ae_pkg.sv
sv/ae_scaler.sv
sv/ae_pack.sv
sv/arithmetic_encoder.sv
dv/testbench.sv
